// File: hdl/hdrp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP response header parser package
// Shared types, limits and text constants of the header parser.
// ----------------------------------------------------------------------------
package hdrp_pkg;

  // Header size limit and the width of the byte counter that follows from it.
  localparam int unsigned MaxHeaderBytes = 4096;
  localparam int unsigned CntW           = $clog2(MaxHeaderBytes + 1);

  // Field widths of the result, the success code and the line position.
  localparam int unsigned CodeW = 16;
  localparam int unsigned LenW  = 31;
  localparam int unsigned HdrW  = 13;
  localparam int unsigned OkW   = 10;
  localparam int unsigned PosW  = 5;

  // Line positions of interest.
  localparam logic [PosW-1:0] PosSat       = PosW'(17);
  localparam logic [PosW-1:0] PosStatusEnd = PosW'(8);
  localparam logic [PosW-1:0] PosCodeStart = PosW'(9);
  localparam logic [PosW-1:0] PosFieldEnd  = PosW'(15);
  localparam logic [PosW-1:0] PosLenStart  = PosW'(16);

  // Saturation limits of the decimal accumulators.
  localparam logic [LenW-1:0] CodeMax = LenW'(65535);
  localparam logic [LenW-1:0] LenMax  = {LenW{1'b1}};

  // Special bytes.
  localparam logic [7:0] CrByte = 8'h0d;
  localparam logic [7:0] LfByte = 8'h0a;

  // Text that the status line and the length header must begin with.
  localparam logic [0:7][7:0]  StatusText = "HTTP/1.1";
  localparam logic [0:14][7:0] FieldText  = "Content-Length:";

  // Terminator progress codes.
  typedef enum logic [1:0] {
    TermNone  = 2'd0,
    TermCr    = 2'd1,
    TermCrLf  = 2'd2,
    TermCrLfCr = 2'd3
  } term_e;

  // One input transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_flag;
  } hdrp_in_t;

  // One result transaction.
  typedef struct packed {
    logic [CodeW-1:0] response_code;
    logic [LenW-1:0]  content_length;
    logic             status_valid;
    logic             response_ok;
    logic [HdrW-1:0]  header_bytes;
    logic             overflow;
  } hdrp_out_t;

endpackage : hdrp_pkg
`default_nettype wire

// File: hdl/hdrp_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted input transaction until the parser stage takes it.
// ----------------------------------------------------------------------------
module hdrp_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire hdrp_pkg::hdrp_in_t in_data_i,
  output logic                   held_valid_o,
  output hdrp_pkg::hdrp_in_t     held_data_o,
  input  wire logic              take_i
);
  import hdrp_pkg::*;

  logic     valid_q, valid_d;
  hdrp_in_t data_q;

  // The register accepts when it is empty or is emptied in this cycle.
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_data_o  = data_q;

endmodule : hdrp_in_reg
`default_nettype wire

// File: hdl/hdrp_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Header parser core
// Parse state and the per-byte update of the status line, the length header
// and the terminator search; produces at most one result per byte.
// ----------------------------------------------------------------------------
module hdrp_parser (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [hdrp_pkg::OkW-1:0] cfg_data_i,
  input  wire logic                   step_i,
  input  wire hdrp_pkg::hdrp_in_t     item_i,
  output logic                        res_valid_o,
  output hdrp_pkg::hdrp_out_t         res_o
);
  import hdrp_pkg::*;

  typedef struct packed {
    logic [CntW-1:0] byte_count;
    logic [PosW-1:0] line_position;
    logic            first_line;
    logic            prefix_match;
    logic [CodeW-1:0] code_acc;
    logic            code_done;
    logic            field_match;
    logic [LenW-1:0] length_acc;
    logic            length_done;
    logic [LenW-1:0] length_result;
    term_e           term;
    logic            finished;
  } parse_t;

  localparam parse_t ParseClear = '{
    byte_count:    '0,
    line_position: '0,
    first_line:    1'b1,
    prefix_match:  1'b1,
    code_acc:      '0,
    code_done:     1'b0,
    field_match:   1'b1,
    length_acc:    '0,
    length_done:   1'b0,
    length_result: '0,
    term:          TermNone,
    finished:      1'b0
  };

  // Multiply by ten, add a digit and saturate at the given limit.
  function automatic logic [LenW-1:0] add_digit(input logic [LenW-1:0] acc,
                                                input logic [3:0] digit,
                                                input logic [LenW-1:0] limit);
    logic [LenW+3:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (LenW+4)'(digit);
    return (v > (LenW+4)'(limit)) ? limit : v[LenW-1:0];
  endfunction

  parse_t             st_q, st, st_d;
  logic [OkW-1:0]     ok_code_q;
  logic [7:0]         b;
  logic               is_digit;
  logic [3:0]         digit;
  logic               after_cr;
  logic [CntW-1:0]    cnt_next;
  logic [CodeW-1:0]   code;
  hdrp_out_t          res;
  logic               res_valid;

  assign b        = item_i.data_byte;
  assign is_digit = (b >= 8'h30) && (b <= 8'h39);
  assign digit    = 4'(b - 8'h30);

  // Next parse state and result for one byte.
  always_comb begin
    st        = item_i.start_flag ? ParseClear : st_q;
    st_d      = st;
    res       = '0;
    res_valid = 1'b0;
    after_cr  = st.term[0];
    cnt_next  = st.byte_count + CntW'(1);
    code      = st.prefix_match ? st.code_acc : '0;

    if (!st.finished) begin
      // Line content; the byte after a CR is skipped.
      if (!after_cr) begin
        if (b == CrByte) begin
          if (st.field_match && st.line_position == PosSat) begin
            st_d.length_result = st.length_acc;
          end
          if (st.first_line) begin
            if (st.line_position < PosStatusEnd) begin
              st_d.prefix_match = 1'b0;
            end
            st_d.code_done = 1'b1;
          end
          st_d.first_line    = 1'b0;
          st_d.line_position = '0;
          st_d.field_match   = 1'b1;
          st_d.length_acc    = '0;
          st_d.length_done   = 1'b0;
        end else begin
          if (st.first_line) begin
            if (st.line_position < PosStatusEnd &&
                b != StatusText[st.line_position[2:0]]) begin
              st_d.prefix_match = 1'b0;
            end
            if (st.line_position >= PosCodeStart && !st.code_done) begin
              if (is_digit) begin
                st_d.code_acc = CodeW'(add_digit(LenW'(st.code_acc), digit, CodeMax));
              end else begin
                st_d.code_done = 1'b1;
              end
            end
          end
          if (st.line_position < PosFieldEnd &&
              b != FieldText[st.line_position[3:0]]) begin
            st_d.field_match = 1'b0;
          end
          if (st.line_position >= PosLenStart && st.field_match && !st.length_done) begin
            if (is_digit) begin
              st_d.length_acc = add_digit(st.length_acc, digit, LenMax);
            end else begin
              st_d.length_done = 1'b1;
            end
          end
          if (st.line_position < PosSat) begin
            st_d.line_position = st.line_position + PosW'(1);
          end
        end
      end

      st_d.byte_count = cnt_next;

      // Terminator search, then the size limit.
      if (b == LfByte && after_cr && st.term == TermCrLfCr) begin
        st_d.finished          = 1'b1;
        res_valid              = 1'b1;
        res.response_code      = code;
        res.content_length     = st.prefix_match ? st.length_result : '0;
        res.status_valid       = st.prefix_match;
        res.response_ok        = st.prefix_match && (code == CodeW'(ok_code_q));
        res.header_bytes       = HdrW'(cnt_next);
        res.overflow           = 1'b0;
      end else begin
        if (b == CrByte) begin
          st_d.term = (st.term == TermCrLf) ? TermCrLfCr : TermCr;
        end else if (b == LfByte && after_cr) begin
          st_d.term = TermCrLf;
        end else begin
          st_d.term = TermNone;
        end
        if (cnt_next >= CntW'(MaxHeaderBytes)) begin
          st_d.finished    = 1'b1;
          res_valid        = 1'b1;
          res.header_bytes = HdrW'(cnt_next);
          res.overflow     = 1'b1;
        end
      end
    end
  end

  // Parse state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ParseClear;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  // Success code register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_code_q <= OkW'(200);
    end else if (cfg_we_i) begin
      ok_code_q <= cfg_data_i;
    end
  end

  assign res_valid_o = res_valid;
  assign res_o       = res;

endmodule : hdrp_parser
`default_nettype wire

// File: hdl/hdrp_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Result register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module hdrp_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire hdrp_pkg::hdrp_out_t res_i,
  output logic                     space_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output hdrp_pkg::hdrp_out_t      out_data_o
);
  import hdrp_pkg::*;

  logic      valid_q, valid_d;
  hdrp_out_t data_q;

  // There is room when the register is empty or drains in this cycle.
  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule : hdrp_out_reg
`default_nettype wire

// File: hdl/http_response_header_parser_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP response header parser, top level
// Byte-stream parser for HTTP/1.1 response headers with one result per header.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle with no gaps of its own: a byte is
// registered at acceptance, parsed from the input register once the result
// register has room, and its result, if any, lands in the result register at
// the edge that completes the parse. The rate is set by the single parse stage
// between the input register and the result register; it stalls only while
// the result register holds a result that has not been taken.
module http_response_header_parser_top (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [hdrp_pkg::OkW-1:0] cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire hdrp_pkg::hdrp_in_t       in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output hdrp_pkg::hdrp_out_t           out_data_o
);
  import hdrp_pkg::*;

  logic      held_valid;
  hdrp_in_t  held_data;
  logic      step;
  logic      space;
  logic      res_valid;
  hdrp_out_t res;

  // A byte is parsed when one is held and the result register has room.
  assign step = held_valid && space;

  hdrp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .held_valid_o (held_valid),
    .held_data_o  (held_data),
    .take_i       (step)
  );

  hdrp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .item_i      (held_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hdrp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule : http_response_header_parser_top
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP response header parser testbench
// Streams generated HTTP responses into the parser one byte per transaction,
// predicts each header summary and compares it field by field with the
// results taken from the output channel, under random bursts and stalls.
// ----------------------------------------------------------------------------
module testbench;
  import hdrp_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int LongHoldOff   = 400;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [OkW-1:0]  cfg_data_i  = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  hdrp_in_t        in_data_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  hdrp_out_t       out_data_o;

  // Bytes waiting to be offered and header summaries waiting to be seen.
  hdrp_in_t        tx_bytes[$];
  hdrp_out_t       expected_headers[$];

  // Shadow copy of the success code register.
  logic [OkW-1:0]  ok_code_cfg = OkW'(200);

  // Parser state as predicted by the testbench.
  int unsigned     hb_count;
  logic [PosW-1:0] line_pos;
  bit              on_status_line;
  bit              status_ok;
  int unsigned     code_acc;
  bit              code_closed;
  bit              name_ok;
  longint unsigned len_acc;
  bit              len_closed;
  longint unsigned len_latched;
  term_e           term_st;
  bit              header_done;

  int              mismatch_count = 0;
  int              results_taken  = 0;
  int unsigned     bytes_made     = 0;
  bit              start_pending  = 1'b0;

  int              burst_left = 0;
  int              gap_left   = 0;
  int              stall_mode = 0;
  int              mode_left  = 0;
  int              hold_left  = 0;
  bit              long_hold_done = 1'b0;
  int unsigned     rx_cycle   = 0;
  int              idle_cycles = 0;

  http_response_header_parser_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Header summary prediction
  // --------------------------------------------------------------------------

  function automatic void clear_parse_state();
    hb_count       = 0;
    line_pos       = '0;
    on_status_line = 1'b1;
    status_ok      = 1'b1;
    code_acc       = 0;
    code_closed    = 1'b0;
    name_ok        = 1'b1;
    len_acc        = 0;
    len_closed     = 1'b0;
    len_latched    = 0;
    term_st        = TermNone;
    header_done    = 1'b0;
  endfunction

  // One more decimal digit, clamped at the given limit.
  function automatic longint unsigned add_decimal(longint unsigned acc, logic [7:0] ch,
                                                  longint unsigned lim);
    longint unsigned v;
    v = acc * 10 + (ch - "0");
    return (v > lim) ? lim : v;
  endfunction

  // Line content byte: status prefix, code digits, length field digits.
  function automatic void parse_line_byte(logic [7:0] b);
    logic [PosW-1:0] p;
    bit              dig;
    p   = line_pos;
    dig = (b >= "0") && (b <= "9");
    if (b == CrByte) begin
      if (name_ok && p == PosSat) len_latched = len_acc;
      if (on_status_line) begin
        if (p < PosStatusEnd) status_ok = 1'b0;
        code_closed = 1'b1;
      end
      on_status_line = 1'b0;
      line_pos       = '0;
      name_ok        = 1'b1;
      len_acc        = 0;
      len_closed     = 1'b0;
      return;
    end
    if (on_status_line) begin
      if (p < PosStatusEnd && b != StatusText[p]) status_ok = 1'b0;
      if (p >= PosCodeStart && !code_closed) begin
        if (dig) code_acc = int'(add_decimal(code_acc, b, 65535));
        else code_closed = 1'b1;
      end
    end
    if (p < PosFieldEnd && b != FieldText[p]) name_ok = 1'b0;
    if (p >= PosLenStart && name_ok && !len_closed) begin
      if (dig) len_acc = add_decimal(len_acc, b, 64'h7fff_ffff);
      else len_closed = 1'b1;
    end
    line_pos = (p < PosSat) ? p + 1'b1 : PosSat;
  endfunction

  // Advances the predicted parser by one accepted byte and queues any summary.
  function automatic void parse_header_byte(hdrp_in_t item);
    bit          after_cr;
    hdrp_out_t   res;
    logic [7:0]  b;
    b = item.data_byte;
    if (item.start_flag) clear_parse_state();
    if (header_done) return;
    after_cr = (term_st == TermCr) || (term_st == TermCrLfCr);
    if (!after_cr) parse_line_byte(b);
    hb_count++;
    res = '0;
    if (b == CrByte) begin
      term_st = (term_st == TermCrLf) ? TermCrLfCr : TermCr;
    end else if (b == LfByte && after_cr) begin
      if (term_st == TermCrLfCr) begin
        header_done        = 1'b1;
        res.response_code  = status_ok ? CodeW'(code_acc) : '0;
        res.content_length = status_ok ? LenW'(len_latched) : '0;
        res.status_valid   = status_ok;
        res.response_ok    = status_ok && (code_acc == int'(ok_code_cfg));
        res.header_bytes   = HdrW'(hb_count);
        expected_headers.push_back(res);
        return;
      end
      term_st = TermCrLf;
    end else begin
      term_st = TermNone;
    end
    if (hb_count >= MaxHeaderBytes) begin
      header_done      = 1'b1;
      res.header_bytes = HdrW'(hb_count);
      res.overflow     = 1'b1;
      expected_headers.push_back(res);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_header(hdrp_out_t got);
    hdrp_out_t want;
    if (expected_headers.size() == 0) begin
      report_mismatch("result with none pending (header_bytes)", 64'(got.header_bytes), 0);
      return;
    end
    want = expected_headers.pop_front();
    if (got.response_code !== want.response_code)
      report_mismatch("response_code", 64'(got.response_code), 64'(want.response_code));
    if (got.content_length !== want.content_length)
      report_mismatch("content_length", 64'(got.content_length), 64'(want.content_length));
    if (got.status_valid !== want.status_valid)
      report_mismatch("status_valid", 64'(got.status_valid), 64'(want.status_valid));
    if (got.response_ok !== want.response_ok)
      report_mismatch("response_ok", 64'(got.response_ok), 64'(want.response_ok));
    if (got.header_bytes !== want.header_bytes)
      report_mismatch("header_bytes", 64'(got.header_bytes), 64'(want.header_bytes));
    if (got.overflow !== want.overflow)
      report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued bytes in bursts separated by random gaps.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && in_ready_o) parse_header_byte(in_data_i);
      // A new transaction may be offered once the current one is gone.
      if (!in_valid_i || in_ready_o) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (tx_bytes.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= tx_bytes.pop_front();
          burst_left--;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes results under a changing stall pattern with long hold-offs.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
      mode_left = 0;
    end else begin
      rx_cycle++;
      if (out_valid_o && out_ready_i) begin
        check_header(out_data_o);
        results_taken++;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      // One guaranteed long hold-off so the parser backs up, plus rare short ones.
      if (hold_left == 0 && !long_hold_done && results_taken >= 6) begin
        hold_left      = LongHoldOff;
        long_hold_done = 1'b1;
      end else if (hold_left == 0 && $urandom_range(0, 999) == 0) begin
        hold_left = $urandom_range(20, 120);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 1) != 0);
          default: out_ready_i <= (rx_cycle % 4 == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("testbench NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic send_byte(logic [7:0] b);
    hdrp_in_t it;
    it.data_byte  = b;
    it.start_flag = start_pending;
    start_pending = 1'b0;
    tx_bytes.push_back(it);
    bytes_made++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(CrByte);
    send_byte(LfByte);
  endtask

  task automatic send_digits(int n);
    repeat (n) send_byte(8'("0" + $urandom_range(0, 9)));
  endtask

  // Any byte except CR, so that it stays inside the current line.
  function automatic logic [7:0] text_byte();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255)); while (ch == CrByte);
    return ch;
  endfunction

  task automatic send_junk(int n);
    repeat (n) send_byte(text_byte());
  endtask

  // Status line, mostly well formed, sometimes short or with a bad prefix.
  task automatic send_status_line();
    int         cut;
    int         bad_pos;
    logic [7:0] ch;
    cut     = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 7) : 8;
    bad_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8;
    for (int i = 0; i < cut; i++) begin
      ch = StatusText[i];
      if (i == bad_pos) ch = ch ^ (8'd1 << $urandom_range(0, 7));
      send_byte(ch);
    end
    if (cut == 8) begin
      send_byte(($urandom_range(0, 4) == 0) ? text_byte() : 8'(" "));
      case ($urandom_range(0, 7))
        0, 1, 2: send_text($sformatf("%0d", ok_code_cfg));
        3:       send_text($sformatf("%0d", $urandom_range(100, 599)));
        4:       send_digits($urandom_range(5, 9));
        5: begin
          send_byte(($urandom_range(0, 1) != 0) ? 8'("+") : 8'("-"));
          send_digits($urandom_range(1, 3));
        end
        6:       ;
        default: send_text($sformatf("%0d", $urandom_range(0, 1023)));
      endcase
      if ($urandom_range(0, 1) != 0) send_text(" OK");
      else send_junk($urandom_range(0, 10));
    end
    send_crlf();
  endtask

  // Content-Length line with a value of random shape.
  task automatic send_length_line();
    send_text("Content-Length:");
    send_byte(($urandom_range(0, 4) == 0) ? text_byte() : 8'(" "));
    case ($urandom_range(0, 7))
      0: send_text($sformatf("%0d", $urandom));
      1: send_digits($urandom_range(10, 14));
      2: begin
        send_byte(($urandom_range(0, 1) != 0) ? 8'("+") : 8'("-"));
        send_digits($urandom_range(1, 4));
      end
      3: ;
      4: send_text("2147483647");
      default: send_text($sformatf("%0d", $urandom_range(0, 99999)));
    endcase
    if ($urandom_range(0, 3) == 0) send_junk($urandom_range(1, 6));
    send_crlf();
  endtask

  task automatic send_header_line();
    int         bad_pos;
    logic [7:0] ch;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: send_length_line();
      // Field name with one character replaced.
      5: begin
        bad_pos = $urandom_range(0, 14);
        for (int i = 0; i < 15; i++) begin
          ch = FieldText[i];
          if (i == bad_pos) ch = ($urandom_range(0, 1) != 0) ? (ch ^ 8'h20) : text_byte();
          send_byte(ch);
        end
        send_text($sformatf(" %0d", $urandom_range(0, 9999)));
        send_crlf();
      end
      // The byte following a CR is dropped, even when it is not LF.
      6: begin
        send_text("X-Id: ");
        send_junk($urandom_range(0, 5));
        send_byte(CrByte);
        do ch = 8'($urandom_range(0, 255)); while (ch == LfByte);
        send_byte(ch);
        if ($urandom_range(0, 1) != 0) send_length_line();
        else send_crlf();
      end
      default: begin
        send_text("Server: ");
        send_junk($urandom_range(0, 20));
        send_crlf();
      end
    endcase
  endtask

  // Complete response header, optionally followed by body bytes.
  task automatic make_response();
    int n;
    start_pending = ($urandom_range(0, 19) != 0);
    send_status_line();
    repeat ($urandom_range(0, 4)) send_header_line();
    send_crlf();
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Noise, cut-off headers and odd CR/LF runs.
  task automatic send_broken();
    start_pending = 1'b1;
    case ($urandom_range(0, 2))
      0: repeat ($urandom_range(1, 40)) send_byte(8'($urandom_range(0, 255)));
      1: begin
        send_status_line();
        if ($urandom_range(0, 1) != 0) send_text("Content-Len");
      end
      default: begin
        send_text($sformatf("HTTP/1.1 %0d", ok_code_cfg));
        send_byte(CrByte);
        send_byte(CrByte);
        send_byte(LfByte);
        send_byte(LfByte);
        send_crlf();
        send_crlf();
      end
    endcase
  endtask

  task automatic run_random(int unsigned target);
    int unsigned base;
    int          n;
    base = bytes_made;
    n    = 0;
    while (bytes_made - base < target || n < 16) begin
      if ($urandom_range(0, 9) == 0) send_broken();
      else make_response();
      n++;
    end
  endtask

  // Waits until every byte is accepted and every summary seen, then lets the
  // parser settle.
  task automatic wait_drained();
    while (tx_bytes.size() != 0 || in_valid_i || expected_headers.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_ok_code(logic [OkW-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ok_code_cfg = v;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_parse_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty header without status line, minimal success response
    // under the reset code, then bytes that must be ignored.
    start_pending = 1'b1;
    send_crlf();
    send_crlf();
    start_pending = 1'b1;
    send_text("HTTP/1.1 200");
    send_crlf();
    send_crlf();
    send_byte(8'hff);
    send_byte(8'h00);
    wait_drained();

    write_ok_code(OkW'(100));
    run_random(550);
    wait_drained();

    write_ok_code(OkW'(599));
    run_random(550);
    wait_drained();

    write_ok_code(OkW'($urandom_range(101, 598)));
    run_random(550);
    make_response();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/hdrp_pkg.sv
hdl/hdrp_in_reg.sv
hdl/hdrp_parser.sv
hdl/hdrp_out_reg.sv
hdl/http_response_header_parser_top.sv
verif/testbench.sv
